FILE: rtl/core/mtav_pkg.sv
// Shared types and constants for the multi-turn angle and velocity tracker.
// No dependencies; imported by every module of the block.

package mtav_pkg;

    localparam int ANGLE_BITS_DEF  = 12;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int TURN_W  = 32;
    localparam int TOTAL_W = 44;
    localparam int TIME_W  = 32;
    localparam int VEL_W   = 32;
    localparam int FB_W    = 16;
    localparam int MAX_W   = 20;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // numerator of the velocity division: magnitude * 10^6 (< 2^63)
    localparam int NUM_W   = 64;
    localparam int MUL_A_W = TOTAL_W / 2;
    localparam int US_W    = 20;
    localparam int PROD_W  = MUL_A_W + US_W;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [US_W-1:0]    US_PER_S  = US_W'(1000000);
    localparam logic [FB_W-1:0]    FB_RESET  = FB_W'(1000);
    localparam logic [MAX_W-1:0]   MAX_RESET = MAX_W'(50000);
    localparam logic [NUM_W-1:0]   VEL_POS_LIM = NUM_W'(64'h7FFF_FFFF);
    localparam logic [NUM_W-1:0]   VEL_NEG_LIM = NUM_W'(64'h8000_0000);
    localparam logic [VEL_W-1:0]   VEL_POS_SAT = VEL_W'(32'h7FFF_FFFF);
    localparam logic [VEL_W-1:0]   VEL_NEG_SAT = VEL_W'(32'h8000_0000);

    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX      = CFG_IDX_W'(1);

    localparam int M_DATA_W = ((TURN_W + TOTAL_W + VEL_W + 7) / 8) * 8;
    localparam int M_PAD_W  = M_DATA_W - (TURN_W + TOTAL_W + VEL_W);

    typedef struct packed {
        logic [FB_W-1:0]  fallback_us;
        logic [MAX_W-1:0] max_us;
    } cfg_t;

    // one classified sample handed from front to back
    typedef struct packed {
        logic                mode;
        logic [TURN_W-1:0]   turns;
        logic [TOTAL_W-1:0]  total;
        logic [TIME_W-1:0]   time_us;
    } entry_t;

endpackage

FILE: rtl/core/mtav_front.sv
// Front end: accepts samples, tracks wraps and the turn count, builds the
// accumulated angle and pushes each sample into the queue. Uses mtav_pkg.

module mtav_front #(
    parameter int ANGLE_BITS = mtav_pkg::ANGLE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         mode,
    input  logic [ANGLE_BITS-1:0]        raw_angle,
    input  logic [mtav_pkg::TIME_W-1:0]  time_us,
    input  logic                         q_full,
    output logic                         push,
    output mtav_pkg::entry_t             push_entry
);
    import mtav_pkg::*;

    localparam int HALF_I = 1 << (ANGLE_BITS - 1);
    localparam logic signed [ANGLE_BITS:0] HALF_P = (ANGLE_BITS + 1)'(HALF_I);
    localparam logic signed [ANGLE_BITS:0] HALF_N = -HALF_P;

    logic [ANGLE_BITS-1:0]      last_raw_reg, last_raw_next;
    logic [TURN_W-1:0]          turn_reg, turn_next;
    logic signed [ANGLE_BITS:0] delta;
    logic [TOTAL_W-1:0]         turns_ext;

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    always_comb begin
        delta = $signed({1'b0, raw_angle}) - $signed({1'b0, last_raw_reg});
        turn_next     = turn_reg;
        last_raw_next = last_raw_reg;
        if (push) begin
            last_raw_next = raw_angle;
            if (delta > HALF_P) begin
                turn_next = turn_reg - TURN_W'(1);
            end else if (delta < HALF_N) begin
                turn_next = turn_reg + TURN_W'(1);
            end
        end
        turns_ext = {{(TOTAL_W - TURN_W){turn_next[TURN_W-1]}}, turn_next};
    end

    always_comb begin
        push_entry.mode    = mode;
        push_entry.turns   = turn_next;
        push_entry.total   = {turns_ext[TOTAL_W-ANGLE_BITS-1:0], raw_angle};
        push_entry.time_us = time_us;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg <= '0;
            turn_reg     <= '0;
        end else begin
            last_raw_reg <= last_raw_next;
            turn_reg     <= turn_next;
        end
    end

endmodule

FILE: rtl/core/mtav_queue.sv
// Short FIFO of classified samples between front and back end.
// Uses mtav_pkg for the entry type.

module mtav_queue #(
    parameter int DEPTH = mtav_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  mtav_pkg::entry_t push_entry,
    input  logic             pop,
    output mtav_pkg::entry_t head,
    output logic             empty,
    output logic             full
);
    import mtav_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/core/mtav_back.sv
// Back end: takes samples from the queue, computes velocity with a split
// multiply and a radix-2 restoring divider, and drives the result register.
// Uses mtav_pkg.

module mtav_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mtav_pkg::cfg_t               cfg,
    input  mtav_pkg::entry_t             head,
    input  logic                         empty,
    output logic                         pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [mtav_pkg::TURN_W-1:0]  m_turns,
    output logic [mtav_pkg::TOTAL_W-1:0] m_total,
    output logic [mtav_pkg::VEL_W-1:0]   m_velocity,
    output logic                         m_vel_valid
);
    import mtav_pkg::*;

    typedef enum logic [7:0] {
        B_IDLE   = 8'b0000_0001,
        B_PREP   = 8'b0000_0010,
        B_MAG    = 8'b0000_0100,
        B_MUL_LO = 8'b0000_1000,
        B_MUL_HI = 8'b0001_0000,
        B_ADD    = 8'b0010_0000,
        B_DIV    = 8'b0100_0000,
        B_FIN    = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    entry_t               cur_reg, cur_next;
    logic [TOTAL_W-1:0]   vlt_reg, vlt_next;
    logic [TIME_W-1:0]    vtime_reg, vtime_next;
    logic [MAX_W-1:0]     dt_reg, dt_next;
    logic [TOTAL_W-1:0]   diff_reg, diff_next;
    logic [TOTAL_W-1:0]   mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [PROD_W-1:0]    lo_reg, lo_next;
    logic [PROD_W-1:0]    hi_reg, hi_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [MAX_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic                 m_valid_reg, m_valid_next;
    logic [TURN_W-1:0]    m_turns_reg, m_turns_next;
    logic [TOTAL_W-1:0]   m_total_reg, m_total_next;
    logic [VEL_W-1:0]     m_vel_reg, m_vel_next;
    logic                 m_vv_reg, m_vv_next;

    logic [TIME_W-1:0]    dt_raw, dt_fb;
    logic [FB_W-1:0]      fb1;
    logic [MAX_W-1:0]     mx1;
    logic [MUL_A_W-1:0]   mul_a;
    logic [PROD_W-1:0]    prod;
    logic [MAX_W:0]       trial, rem_sub;
    logic                 ge;
    logic [VEL_W-1:0]     vel_sat;
    logic                 out_free;

    assign pop      = (state_reg == B_IDLE) && !empty;
    assign out_free = !m_valid_reg || m_ready;

    // zero-valued registers behave as one
    assign fb1    = (cfg.fallback_us == '0) ? FB_W'(1) : cfg.fallback_us;
    assign mx1    = (cfg.max_us == '0) ? MAX_W'(1) : cfg.max_us;
    assign dt_raw = cur_reg.time_us - vtime_reg;
    assign dt_fb  = (dt_raw == '0) ? TIME_W'(fb1) : dt_raw;

    // one shared 22x20 multiplier, used for both halves of the magnitude
    assign mul_a = (state_reg == B_MUL_LO) ? mag_reg[MUL_A_W-1:0]
                                           : mag_reg[TOTAL_W-1:MUL_A_W];
    assign prod  = PROD_W'(mul_a) * PROD_W'(US_PER_S);

    assign trial   = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_sub = trial - {1'b0, dt_reg};
    assign ge      = (trial >= {1'b0, dt_reg});

    always_comb begin
        if (neg_reg) begin
            vel_sat = (quo_reg > VEL_NEG_LIM) ? VEL_NEG_SAT : (VEL_W'(0) - quo_reg[VEL_W-1:0]);
        end else begin
            vel_sat = (quo_reg > VEL_POS_LIM) ? VEL_POS_SAT : quo_reg[VEL_W-1:0];
        end
    end

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        vlt_next     = vlt_reg;
        vtime_next   = vtime_reg;
        dt_next      = dt_reg;
        diff_next    = diff_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_turns_next = m_turns_reg;
        m_total_next = m_total_reg;
        m_vel_next   = m_vel_reg;
        m_vv_next    = m_vv_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE: begin
                if (!empty) begin
                    cur_next   = head;
                    state_next = B_PREP;
                end
            end
            B_PREP: begin
                if (cur_reg.mode) begin
                    dt_next    = (dt_fb >= TIME_W'(mx1)) ? mx1 : dt_fb[MAX_W-1:0];
                    diff_next  = cur_reg.total - vlt_reg;
                    vlt_next   = cur_reg.total;
                    vtime_next = cur_reg.time_us;
                    state_next = B_MAG;
                end else begin
                    state_next = B_FIN;
                end
            end
            B_MAG: begin
                neg_next   = diff_reg[TOTAL_W-1];
                mag_next   = diff_reg[TOTAL_W-1] ? (~diff_reg + TOTAL_W'(1)) : diff_reg;
                state_next = B_MUL_LO;
            end
            B_MUL_LO: begin
                lo_next    = prod;
                state_next = B_MUL_HI;
            end
            B_MUL_HI: begin
                hi_next    = prod;
                state_next = B_ADD;
            end
            B_ADD: begin
                quo_next   = {hi_reg, {MUL_A_W{1'b0}}} + NUM_W'(lo_reg);
                rem_next   = '0;
                cnt_next   = DIV_CNT_W'(NUM_W - 1);
                state_next = B_DIV;
            end
            B_DIV: begin
                rem_next = ge ? rem_sub[MAX_W-1:0] : trial[MAX_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], ge};
                cnt_next = cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = B_FIN;
                end
            end
            B_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_turns_next = cur_reg.turns;
                    m_total_next = cur_reg.total;
                    m_vel_next   = cur_reg.mode ? vel_sat : '0;
                    m_vv_next    = cur_reg.mode;
                    state_next   = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            vlt_reg     <= '0;
            vtime_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            vlt_reg     <= vlt_next;
            vtime_reg   <= vtime_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        dt_reg      <= dt_next;
        diff_reg    <= diff_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        m_turns_reg <= m_turns_next;
        m_total_reg <= m_total_next;
        m_vel_reg   <= m_vel_next;
        m_vv_reg    <= m_vv_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_turns     = m_turns_reg;
    assign m_total     = m_total_reg;
    assign m_velocity  = m_vel_reg;
    assign m_vel_valid = m_vv_reg;

    a_angle_only_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_vv_reg) |-> (m_vel_reg == '0))
        else $error("angle-only result carries non-zero velocity");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_DIV) |-> (dt_reg != '0))
        else $error("divider running with zero divisor");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_DIV) |-> (rem_reg < dt_reg))
        else $error("divider remainder out of range");

    a_load_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == B_FIN))
        else $error("result register loaded outside the finish step");

endmodule

FILE: rtl/core/multi_turn_angle_velocity_tracker.sv
// Multi-turn angle and velocity tracker: top level.
// Holds the configuration registers; instantiates mtav_front, mtav_queue and
// mtav_back. Uses mtav_pkg.
//
// Usage:
//   s_ channel: one angle sample per transfer; s_tuser = mode (1 = also update
//   velocity), s_tdata = raw angle then timestamp in us.
//   m_ channel: one result per sample, in order; m_tuser = velocity_valid,
//   m_tdata = turns, accumulated angle, velocity in counts per second.
//   cfg channel: cfg_index selects the register (0 fallback interval,
//   1 maximum interval), cfg_data the value; always ready, unknown indices
//   are dropped. Write only while the block is idle.
// Timing: the front takes a sample per cycle while the queue has room. The
//   back takes one sample at a time and pops the next only after its finish
//   step; an angle-only sample goes idle, prepare, finish; a velocity sample
//   also goes through magnitude, low and high multiply, add and the 64-step
//   one-bit-per-cycle divider before the finish step.
// Reset clears turn count, last angle, velocity history, the queue and the
//   result valid flag, and loads the register defaults (1000 us, 50000 us).
// A stalled receiver holds the result; the back then waits in its finish
//   step and the front keeps accepting until the queue is full.

module multi_turn_angle_velocity_tracker #(
    parameter int ANGLE_BITS  = mtav_pkg::ANGLE_BITS_DEF,
    parameter int QUEUE_DEPTH = mtav_pkg::QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // [ANGLE_BITS-1:0] raw_angle, then time_us (32), zero padded to bytes
    input  logic [((ANGLE_BITS + mtav_pkg::TIME_W + 7) / 8) * 8 - 1:0] s_tdata,
    // [0] mode
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // [31:0] turns, [75:32] total_angle, [107:76] velocity, zero padded
    output logic [mtav_pkg::M_DATA_W-1:0] m_tdata,
    // [0] velocity_valid
    output logic m_tuser,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [mtav_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mtav_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mtav_pkg::*;

    logic [FB_W-1:0]     fb_reg, fb_next;
    logic [MAX_W-1:0]    mx_reg, mx_next;
    cfg_t                cfg;
    entry_t              push_entry, head;
    logic                push, pop, q_empty, q_full;
    logic [TURN_W-1:0]   turns;
    logic [TOTAL_W-1:0]  total;
    logic [VEL_W-1:0]    velocity;
    logic                vel_valid;

    assign cfg_ready = 1'b1;

    always_comb begin
        fb_next = fb_reg;
        mx_next = mx_reg;
        if (cfg_valid) begin
            if (cfg_index == REG_FALLBACK) begin
                fb_next = cfg_data[FB_W-1:0];
            end else if (cfg_index == REG_MAX) begin
                mx_next = cfg_data[MAX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_reg <= FB_RESET;
            mx_reg <= MAX_RESET;
        end else begin
            fb_reg <= fb_next;
            mx_reg <= mx_next;
        end
    end

    assign cfg.fallback_us = fb_reg;
    assign cfg.max_us      = mx_reg;

    mtav_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .mode       (s_tuser),
        .raw_angle  (s_tdata[ANGLE_BITS-1:0]),
        .time_us    (s_tdata[ANGLE_BITS +: TIME_W]),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    mtav_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    mtav_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .head        (head),
        .empty       (q_empty),
        .pop         (pop),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_turns     (turns),
        .m_total     (total),
        .m_velocity  (velocity),
        .m_vel_valid (vel_valid)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, velocity, total, turns};
    assign m_tuser = vel_valid;

endmodule
